[rtl/two_level_slot_allocator_defines.svh]
// assertion macros for the slot allocator
`ifndef TWO_LEVEL_SLOT_ALLOCATOR_DEFINES_SVH
`define TWO_LEVEL_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TLSA_CHECK_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// next-cycle implication, sampled on clk, off during reset
`define TLSA_CHECK_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

[rtl/tlsa_pkg.sv]
// types, constants and helper functions shared by the slot allocator
package tlsa_pkg;

	localparam int MAX_POOLS = 16;
	localparam int MAX_SLOTS = 64;
	localparam int POOL_W    = 4;
	localparam int SLOT_W    = 6;
	localparam int CNT_W     = 5;
	localparam int SPP_W     = 7;
	localparam int STATUS_W  = 2;
	localparam int BYTE_W    = 8;
	localparam int GRP_W     = 3;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [SPP_W-1:0] SPP_RESET = 7'd64;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BAD_FREE = 2'd2;

	localparam logic REG_SLOTS_PER_POOL = 1'b0;

	typedef struct packed {
		logic              command;
		logic [SLOT_W-1:0] free_slot;
		logic [POOL_W-1:0] free_pool;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   granted_slot;
		logic [POOL_W-1:0]   granted_pool;
		logic [STATUS_W-1:0] status;
	} res_t;

	typedef struct packed {
		logic load;
		logic step;
	} scan_ctrl_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] idx;
	} scan_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_LOAD,
		S_SCAN,
		S_FREE_WR
	} state_t;

	function automatic logic [SPP_W-1:0] eff_slots(input logic [SPP_W-1:0] spp);
		logic [SPP_W-1:0] n;
		n = spp;
		if (n == '0) n = SPP_W'(1);
		if (n > SPP_W'(MAX_SLOTS)) n = SPP_W'(MAX_SLOTS);
		return n;
	endfunction

	function automatic logic [MAX_SLOTS-1:0] low_mask(input logic [SPP_W-1:0] n);
		logic [MAX_SLOTS-1:0] m;
		if (n >= SPP_W'(MAX_SLOTS)) m = '1;
		else m = (MAX_SLOTS'(1) << n[SLOT_W-1:0]) - MAX_SLOTS'(1);
		return m;
	endfunction

	function automatic logic [POOL_W-1:0] lowest_pool(input logic [MAX_POOLS-1:0] v);
		logic [POOL_W-1:0] p;
		p = '0;
		for (int i = MAX_POOLS - 1; i >= 0; i--) begin
			if (v[i]) p = POOL_W'(i);
		end
		return p;
	endfunction

	function automatic logic [GRP_W-1:0] lowest_bit8(input logic [BYTE_W-1:0] v);
		logic [GRP_W-1:0] b;
		b = '0;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			if (v[i]) b = GRP_W'(i);
		end
		return b;
	endfunction

endpackage

[rtl/two_level_slot_allocator.sv]
// slot allocator top level: sequencer, pool state and config port
//
//  channel   signals                         transfer when
//  request   start, busy, request            start high and busy low
//  result    done, result                    done high (one cycle, no stall)
//  config    psel penable pwrite paddr ...   psel, penable, pwrite, pready high
//
// allocate runs decide with bitmap read, load, then the byte scan of the pool
// bitmap (one byte a cycle, up to 8); opening a pool adds a second decide pass.
// free runs decide with read, then write back. a refusal with all pools full or a
// rejected free ends after decide.
// busy is high from the cycle after start; done rises as busy falls.
// reset clears all pool bookkeeping; the bitmap store needs no clearing.
`include "two_level_slot_allocator_defines.svh"

module two_level_slot_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  tlsa_pkg::req_t                 request,
	output logic                           done,
	output tlsa_pkg::res_t                 result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tlsa_pkg::APB_AW-1:0]    paddr,
	input  logic [tlsa_pkg::APB_DW-1:0]    pwdata,
	output logic [tlsa_pkg::APB_DW-1:0]    prdata,
	output logic                           pready
);
	import tlsa_pkg::*;

	state_t               state_q, state_d;
	req_t                 req_q;
	logic [CNT_W-1:0]     opened_q;
	logic [MAX_POOLS-1:0] has_free_q;
	logic [SPP_W-1:0]     spp_q;
	logic [POOL_W-1:0]    pool_q;
	logic                 done_q;
	res_t                 res_q;

	logic [SPP_W-1:0]     eff;
	logic                 pools_full;
	logic                 bad_free;
	logic [POOL_W-1:0]    low_pool;

	logic                 mem_we;
	logic [POOL_W-1:0]    mem_waddr;
	logic [MAX_SLOTS-1:0] mem_wdata;
	logic [POOL_W-1:0]    mem_raddr;
	logic [MAX_SLOTS-1:0] mem_rdata;

	scan_ctrl_t           scan_ctrl;
	scan_stat_t           scan_stat;
	logic [MAX_SLOTS-1:0] scan_map;

	logic                 open_en, pool_ld, clr_en, set_en, res_fire;
	res_t                 res_d;
	logic                 cfg_wr;

	assign eff        = eff_slots(spp_q);
	assign pools_full = opened_q >= CNT_W'(MAX_POOLS);
	assign bad_free   = ({1'b0, req_q.free_pool} >= opened_q) ||
		({1'b0, req_q.free_slot} >= eff);
	assign low_pool   = lowest_pool(has_free_q);

	tlsa_map_mem u_map_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tlsa_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (scan_ctrl),
		.map_in (mem_rdata),
		.stat   (scan_stat),
		.map    (scan_map)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (req_q.command == CMD_ALLOC) begin
					if (has_free_q == '0) begin
						if (pools_full) state_d = S_IDLE;
					end else begin
						state_d = S_LOAD;
					end
				end else begin
					state_d = bad_free ? S_IDLE : S_FREE_WR;
				end
			end
			S_LOAD: state_d = S_SCAN;
			S_SCAN: begin
				if (scan_stat.found) state_d = S_IDLE;
			end
			S_FREE_WR: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pool_q;
		mem_wdata = '0;
		mem_raddr = pool_q;
		scan_ctrl = '0;
		open_en   = 1'b0;
		pool_ld   = 1'b0;
		clr_en    = 1'b0;
		set_en    = 1'b0;
		res_fire  = 1'b0;
		res_d     = '{granted_slot: '0, granted_pool: '0, status: STAT_OK};
		unique case (state_q)
			S_IDLE: ;
			S_DECIDE: begin
				if (req_q.command == CMD_ALLOC) begin
					if (has_free_q == '0) begin
						if (pools_full) begin
							res_fire     = 1'b1;
							res_d.status = STAT_FULL;
						end else begin
							open_en   = 1'b1;
							mem_we    = 1'b1;
							mem_waddr = opened_q[POOL_W-1:0];
							mem_wdata = low_mask(eff);
						end
					end else begin
						pool_ld   = 1'b1;
						mem_raddr = low_pool;
					end
				end else begin
					mem_raddr = req_q.free_pool;
					if (bad_free) begin
						res_fire     = 1'b1;
						res_d.status = STAT_BAD_FREE;
					end
				end
			end
			S_LOAD: scan_ctrl.load = 1'b1;
			S_SCAN: begin
				scan_ctrl.step = 1'b1;
				if (scan_stat.found) begin
					mem_we             = 1'b1;
					mem_wdata          = scan_map & ~(MAX_SLOTS'(1) << scan_stat.idx);
					clr_en             = (mem_wdata == '0);
					res_fire           = 1'b1;
					res_d.granted_slot = scan_stat.idx;
					res_d.granted_pool = pool_q;
				end
			end
			S_FREE_WR: begin
				mem_we    = 1'b1;
				mem_waddr = req_q.free_pool;
				mem_wdata = mem_rdata | (MAX_SLOTS'(1) << req_q.free_slot);
				set_en    = 1'b1;
				res_fire  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			opened_q   <= '0;
			has_free_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_fire;
			if (open_en) begin
				opened_q   <= opened_q + CNT_W'(1);
				has_free_q <= has_free_q | (MAX_POOLS'(1) << opened_q[POOL_W-1:0]);
			end else if (clr_en) begin
				has_free_q <= has_free_q & ~(MAX_POOLS'(1) << pool_q);
			end else if (set_en) begin
				has_free_q <= has_free_q | (MAX_POOLS'(1) << req_q.free_pool);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) req_q <= request;
		if (pool_ld) pool_q <= low_pool;
		if (res_fire) res_q <= res_d;
	end

	// config register
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[APB_AW-1] == REG_SLOTS_PER_POOL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q <= SPP_RESET;
		end else if (cfg_wr) begin
			spp_q <= pwdata[SPP_W-1:0];
		end
	end

	assign prdata = (paddr[APB_AW-1] == REG_SLOTS_PER_POOL) ?
		{{(APB_DW-SPP_W){1'b0}}, spp_q} : '0;
	assign pready = 1'b1;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	`TLSA_CHECK_NEXT(a_start_goes_busy, start && !busy, busy)
	`TLSA_CHECK_NOW(a_opened_bounded, 1'b1, opened_q <= CNT_W'(MAX_POOLS))
	`TLSA_CHECK_NOW(a_free_only_opened, 1'b1, (has_free_q >> opened_q) == '0)
	`TLSA_CHECK_NOW(a_error_no_grant, done && (result.status != STAT_OK),
		(result.granted_slot == '0) && (result.granted_pool == '0))

endmodule

[rtl/tlsa_map_mem.sv]
// free-slot bitmap store, one row per pool, registered read
module tlsa_map_mem (
	input  logic                           clk,
	input  logic                           we,
	input  logic [tlsa_pkg::POOL_W-1:0]    waddr,
	input  logic [tlsa_pkg::MAX_SLOTS-1:0] wdata,
	input  logic [tlsa_pkg::POOL_W-1:0]    raddr,
	output logic [tlsa_pkg::MAX_SLOTS-1:0] rdata
);
	import tlsa_pkg::*;

	logic [MAX_SLOTS-1:0] mem [MAX_POOLS];
	logic [MAX_SLOTS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/tlsa_scan.sv]
// byte-serial lowest-free-slot finder over one pool bitmap
module tlsa_scan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tlsa_pkg::scan_ctrl_t           ctrl,
	input  logic [tlsa_pkg::MAX_SLOTS-1:0] map_in,
	output tlsa_pkg::scan_stat_t           stat,
	output logic [tlsa_pkg::MAX_SLOTS-1:0] map
);
	import tlsa_pkg::*;

	logic [MAX_SLOTS-1:0] map_q;
	logic [GRP_W-1:0]     grp_q;
	logic [BYTE_W-1:0]    cur_byte;

	assign cur_byte   = map_q[{grp_q, 3'b000} +: BYTE_W];
	assign stat.found = |cur_byte;
	assign stat.idx   = {grp_q, lowest_bit8(cur_byte)};
	assign map        = map_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			map_q <= map_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
		end else if (ctrl.load) begin
			grp_q <= '0;
		end else if (ctrl.step && !stat.found) begin
			grp_q <= grp_q + GRP_W'(1);
		end
	end

endmodule
